[rtl/tone_pattern_sequencer_core_macros.svh]
// Assertion macros shared by the tone pattern sequencer RTL
`ifndef TONE_PATTERN_SEQUENCER_CORE_MACROS_SVH
`define TONE_PATTERN_SEQUENCER_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset
`define TPS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tone sequencer check failed");

// Next-cycle implication, checked outside reset
`define TPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tone sequencer check failed");

`endif

[rtl/tps_pkg.sv]
// Types, constants and helper functions of the tone pattern sequencer
package tps_pkg;

    // Field widths
    localparam int FREQ_W    = 16;
    localparam int DUR_W     = 16;
    localparam int DUTY_W    = 7;
    localparam int VOL_W     = 8;
    localparam int PAT_W     = 3;
    localparam int KIND_W    = 2;
    localparam int PHASE_W   = 9;
    localparam int CFG_IDX_W = 2;

    // Sweep arithmetic: factor and divisor fit 18 bits, product 34 bits,
    // quotient stays below 4 * 65535
    localparam int FACT_W = 18;
    localparam int PROD_W = FREQ_W + FACT_W;
    localparam int QUO_W  = 18;

    // Duty mapping
    localparam int DUTY_RES_BITS = 8;
    localparam int DUTY_TOP      = (1 << DUTY_RES_BITS) / 2 - 1;
    localparam int VOL_SAT       = 100;
    localparam int VOL_IDX_W     = 7;
    localparam int LUT_DEPTH     = 1 << VOL_IDX_W;

    // Queue depths
    localparam int REQ_DEPTH_DEF = 2;
    localparam int RES_DEPTH     = 2;

    // Pattern timing in milliseconds
    localparam logic [PHASE_W-1:0] SIREN_HALF_MS   = 9'd400;
    localparam logic [PHASE_W-1:0] ALARM_TONE_MS   = 9'd150;
    localparam logic [PHASE_W-1:0] ALARM_GAP_MS    = 9'd100;
    localparam logic [PHASE_W-1:0] SWEEP_PERIOD_MS = 9'd30;

    // Register reset values
    localparam logic [FREQ_W-1:0] FREQ_MIN_RST = 16'd100;
    localparam logic [FREQ_W-1:0] FREQ_MAX_RST = 16'd5000;
    localparam logic [DUR_W-1:0]  DUR_MIN_RST  = 16'd10;
    localparam logic [DUR_W-1:0]  DUR_MAX_RST  = 16'd10000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FREQ_MIN = 2'd0,
        CFG_FREQ_MAX = 2'd1,
        CFG_DUR_MIN  = 2'd2,
        CFG_DUR_MAX  = 2'd3
    } cfg_idx_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_TICK = 2'd0,
        KIND_PLAY = 2'd1,
        KIND_STOP = 2'd2
    } kind_t;

    typedef enum logic [PAT_W-1:0] {
        PAT_BEEP   = 3'd0,
        PAT_SIREN  = 3'd1,
        PAT_ALARM  = 3'd2,
        PAT_RISE   = 3'd3,
        PAT_FALL   = 3'd4,
        PAT_CUSTOM = 3'd5
    } pat_t;

    // Classified request codes
    typedef enum logic [2:0] {
        OP_NOP    = 3'd0,
        OP_TICK   = 3'd1,
        OP_PLAY   = 3'd2,
        OP_REJECT = 3'd3,
        OP_STOP   = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        BK_IDLE = 2'd0,
        BK_MUL  = 2'd1,
        BK_LOAD = 2'd2,
        BK_DIV  = 2'd3
    } bk_state_t;

    typedef struct packed {
        logic [FREQ_W-1:0] freq_min;
        logic [FREQ_W-1:0] freq_max;
        logic [DUR_W-1:0]  dur_min;
        logic [DUR_W-1:0]  dur_max;
    } cfg_t;

    typedef struct packed {
        op_t               op;
        pat_t              pattern;
        logic [FREQ_W-1:0] freq;
        logic [DUR_W-1:0]  dur;
        logic [DUTY_W-1:0] duty;
    } req_t;

    typedef struct packed {
        logic [FREQ_W-1:0] freq;
        logic [DUTY_W-1:0] duty;
        logic              playing;
        logic              accepted;
    } res_t;

    typedef logic [DUTY_W-1:0] duty_lut_t [LUT_DEPTH];

    // Raise to lo, then lower to hi (hi wins when lo > hi)
    function automatic logic [FREQ_W-1:0] clamp_val(
        input logic [FACT_W-1:0] v,
        input logic [FREQ_W-1:0] lo,
        input logic [FREQ_W-1:0] hi
    );
        logic [FACT_W-1:0] t;
        t = (v < FACT_W'(lo)) ? FACT_W'(lo) : v;
        if (t > FACT_W'(hi))
        begin
            return hi;
        end
        return t[FREQ_W-1:0];
    endfunction

    // Volume to duty, saturated at 100 percent, evaluated at elaboration
    function automatic duty_lut_t build_duty_lut(input int dmax);
        duty_lut_t lut;
        int        v;
        for (int i = 0; i < LUT_DEPTH; i++)
        begin
            v      = (i > VOL_SAT) ? VOL_SAT : i;
            lut[i] = DUTY_W'((v * dmax) / VOL_SAT);
        end
        return lut;
    endfunction

    localparam duty_lut_t DUTY_LUT = build_duty_lut(DUTY_TOP);

endpackage

[rtl/tone_pattern_sequencer_core.sv]
// Top level of the buzzer tone pattern sequencer: registers and wiring
//
// Requests (tick, play, stop) enter through a queue port: a request is taken
// on a clock edge with push high and full low. Every request yields exactly
// one result (PWM frequency, duty, playing flag, play accepted flag), read
// through a second queue port: the head is valid while empty is low and is
// removed on an edge with pop high.
// Configuration registers (frequency and duration limits) are written over
// cfg_valid/cfg_ready/cfg_index/cfg_data; cfg_ready is always high. Write
// them only while no request is in flight.
// A result can be popped in the cycle after its request is taken for plays,
// stops and most ticks; the back end takes one request per cycle unless the
// result queue is full or a sweep step is busy. A tick on a rise or fall sweep
// step goes through decode, a 34-bit multiply, divider load, 18 serial divider
// steps and the result write; that divider sets the worst-case request rate.
// A front queue of REQ_DEPTH entries and a two-entry result queue let either
// side stall: when results are not popped, the back end holds, the request
// queue fills and full rises.
// Reset (rst_n low, asynchronous) restores the register defaults, silences
// the output, clears both queues and leaves the block idle.
module tone_pattern_sequencer_core import tps_pkg::*; #(
    parameter int REQ_DEPTH = REQ_DEPTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    // request queue
    input  logic                 push,
    output logic                 full,
    input  logic [KIND_W-1:0]    kind,
    input  logic [PAT_W-1:0]     pattern,
    input  logic [FREQ_W-1:0]    freq_hz,
    input  logic [DUR_W-1:0]     duration_ms,
    input  logic [VOL_W-1:0]     volume,
    // result queue
    output logic                 empty,
    input  logic                 pop,
    output logic [FREQ_W-1:0]    out_freq_hz,
    output logic [DUTY_W-1:0]    out_duty,
    output logic                 playing,
    output logic                 accepted,
    // configuration writes
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [FREQ_W-1:0]    cfg_data
);

    cfg_t cfg_reg, cfg_next;
    logic req_valid;
    req_t req;
    logic req_take;
    res_t res_head;

    assign cfg_ready = 1'b1;

    // limit registers
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_FREQ_MIN: cfg_next.freq_min = cfg_data;
                CFG_FREQ_MAX: cfg_next.freq_max = cfg_data;
                CFG_DUR_MIN:  cfg_next.dur_min  = cfg_data;
                CFG_DUR_MAX:  cfg_next.dur_max  = cfg_data;
                default:      cfg_next          = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.freq_min <= FREQ_MIN_RST;
            cfg_reg.freq_max <= FREQ_MAX_RST;
            cfg_reg.dur_min  <= DUR_MIN_RST;
            cfg_reg.dur_max  <= DUR_MAX_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    tps_front #(
        .REQ_DEPTH (REQ_DEPTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .kind        (kind),
        .pattern     (pattern),
        .freq_hz     (freq_hz),
        .duration_ms (duration_ms),
        .volume      (volume),
        .cfg         (cfg_reg),
        .req_valid   (req_valid),
        .req         (req),
        .req_take    (req_take)
    );

    tps_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .req_valid (req_valid),
        .req       (req),
        .req_take  (req_take),
        .empty     (empty),
        .pop       (pop),
        .res_head  (res_head)
    );

    assign out_freq_hz = res_head.freq;
    assign out_duty    = res_head.duty;
    assign playing     = res_head.playing;
    assign accepted    = res_head.accepted;

endmodule

[rtl/tps_front.sv]
// Front end: accepts requests, clamps and classifies them, queues them for the back end
`include "tone_pattern_sequencer_core_macros.svh"

module tps_front import tps_pkg::*; #(
    parameter int REQ_DEPTH = REQ_DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    // request side
    input  logic              push,
    output logic              full,
    input  logic [KIND_W-1:0] kind,
    input  logic [PAT_W-1:0]  pattern,
    input  logic [FREQ_W-1:0] freq_hz,
    input  logic [DUR_W-1:0]  duration_ms,
    input  logic [VOL_W-1:0]  volume,
    input  cfg_t              cfg,
    // queue head toward the back end
    output logic              req_valid,
    output req_t              req,
    input  logic              req_take
);

    localparam int PTR_W = (REQ_DEPTH > 1) ? $clog2(REQ_DEPTH) : 1;
    localparam int CNT_W = $clog2(REQ_DEPTH + 1);

    req_t                 q_mem [REQ_DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 push_ok;
    logic                 pop_ok;
    logic [VOL_IDX_W-1:0] vol_idx;
    req_t                 req_in;

    assign full      = (cnt_reg == CNT_W'(REQ_DEPTH));
    assign req_valid = (cnt_reg != '0);
    assign req       = q_mem[rd_ptr_reg];
    assign push_ok   = push && !full;
    assign pop_ok    = req_take && req_valid;

    // volume above the table saturates at 100 percent
    assign vol_idx = (volume > VOL_W'(VOL_SAT)) ? VOL_IDX_W'(VOL_SAT)
                                                : volume[VOL_IDX_W-1:0];

    // classify the incoming request
    always_comb
    begin
        req_in.op      = OP_NOP;
        req_in.pattern = PAT_BEEP;
        req_in.freq    = '0;
        req_in.dur     = '0;
        req_in.duty    = '0;
        case (kind)
            KIND_TICK:
            begin
                req_in.op = OP_TICK;
            end
            KIND_PLAY:
            begin
                if (pattern > PAT_CUSTOM)
                begin
                    req_in.op = OP_REJECT;
                end
                else
                begin
                    req_in.op      = OP_PLAY;
                    req_in.pattern = pat_t'(pattern);
                    req_in.freq    = clamp_val(FACT_W'(freq_hz), cfg.freq_min, cfg.freq_max);
                    req_in.dur     = clamp_val(FACT_W'(duration_ms), cfg.dur_min, cfg.dur_max);
                    req_in.duty    = DUTY_LUT[vol_idx];
                end
            end
            KIND_STOP:
            begin
                req_in.op = OP_STOP;
            end
            default:
            begin
                req_in.op = OP_NOP;
            end
        endcase
    end

    // queue pointers and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push_ok)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(REQ_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop_ok)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(REQ_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        cnt_next = cnt_reg + CNT_W'(push_ok) - CNT_W'(pop_ok);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            q_mem[wr_ptr_reg] <= req_in;
        end
    end

    `TPS_ASSERT_IMPL(a_take_needs_data, clk, rst_n, req_take, req_valid)
    `TPS_ASSERT_IMPL(a_empty_ptrs_equal, clk, rst_n, cnt_reg == '0, wr_ptr_reg == rd_ptr_reg)
    `TPS_ASSERT_IMPL(a_cnt_in_range, clk, rst_n, 1'b1, cnt_reg <= CNT_W'(REQ_DEPTH))

endmodule

[rtl/tps_div.sv]
// Restoring divider for the sweep frequency, one quotient bit per cycle
module tps_div import tps_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [PROD_W-1:0] dividend,
    input  logic [FACT_W-1:0] divisor,
    output logic              done,
    output logic [QUO_W-1:0]  quotient
);

    localparam int CNT_W = $clog2(QUO_W);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [FACT_W-1:0] rem_reg, rem_next;
    logic [QUO_W-1:0]  quo_reg, quo_next;
    logic [FACT_W-1:0] dvs_reg, dvs_next;
    logic [FACT_W:0]   shifted;
    logic [FACT_W+1:0] diff;
    logic              neg;

    assign done     = done_reg;
    assign quotient = quo_reg;

    // one shift-subtract step
    assign shifted = {rem_reg, quo_reg[QUO_W-1]};
    assign diff    = {1'b0, shifted} - (FACT_W + 2)'(dvs_reg);
    assign neg     = diff[FACT_W+1];

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            // upper part is known to be below the divisor
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = FACT_W'(dividend[PROD_W-1:QUO_W]);
            quo_next  = dividend[QUO_W-1:0];
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = neg ? shifted[FACT_W-1:0] : diff[FACT_W-1:0];
            quo_next = {quo_reg[QUO_W-2:0], !neg};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(QUO_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

endmodule

[rtl/tps_back.sv]
// Back end: pattern state machine, sweep arithmetic and the result queue
`include "tone_pattern_sequencer_core_macros.svh"

module tps_back import tps_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  cfg_t cfg,
    // request queue head
    input  logic req_valid,
    input  req_t req,
    output logic req_take,
    // result queue head
    output logic empty,
    input  logic pop,
    output res_t res_head
);

    localparam int RES_PTR_W = $clog2(RES_DEPTH);
    localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

    bk_state_t          state_reg, state_next;
    logic               active_reg, active_next;
    pat_t               pattern_reg, pattern_next;
    logic [FREQ_W-1:0]  base_reg, base_next;
    logic [DUR_W-1:0]   total_reg, total_next;
    logic [DUTY_W-1:0]  tone_duty_reg, tone_duty_next;
    logic [DUR_W-1:0]   elapsed_reg, elapsed_next;
    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic               tone_on_reg, tone_on_next;
    logic               siren_reg, siren_next;
    logic [FREQ_W-1:0]  freq_reg, freq_next;
    logic [DUTY_W-1:0]  duty_reg, duty_next;
    logic [FACT_W-1:0]  factor_reg, factor_next;
    logic [FACT_W-1:0]  divisor_reg, divisor_next;
    logic [PROD_W-1:0]  product_reg, product_next;

    logic [DUR_W-1:0]   elapsed_inc;
    logic [PHASE_W-1:0] phase_dec;
    logic [FACT_W-1:0]  elapsed_x3;
    logic [FACT_W-1:0]  siren_hi;
    logic               pulsed;
    logic               acc;
    logic               res_push;
    logic               div_start;
    logic               div_done;
    logic [QUO_W-1:0]   div_quo;
    res_t               res_in;

    res_t                 res_mem [RES_DEPTH];
    logic [RES_PTR_W-1:0] res_wr_reg, res_wr_next;
    logic [RES_PTR_W-1:0] res_rd_reg, res_rd_next;
    logic [RES_CNT_W-1:0] res_cnt_reg, res_cnt_next;
    logic                 res_full;
    logic                 res_pop;

    tps_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (product_reg),
        .divisor  (divisor_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    // tick helpers
    assign elapsed_inc = (elapsed_reg != '1) ? elapsed_reg + 1'b1 : elapsed_reg;
    assign phase_dec   = (phase_reg != '0) ? phase_reg - 1'b1 : phase_reg;
    assign elapsed_x3  = {1'b0, elapsed_inc, 1'b0} + FACT_W'(elapsed_inc);
    assign siren_hi    = (FACT_W'(base_reg) + {1'b0, base_reg, 1'b0}) >> 1;
    assign pulsed      = (pattern_reg inside {PAT_SIREN, PAT_ALARM, PAT_RISE, PAT_FALL});

    // pattern state machine
    always_comb
    begin
        state_next     = state_reg;
        active_next    = active_reg;
        pattern_next   = pattern_reg;
        base_next      = base_reg;
        total_next     = total_reg;
        tone_duty_next = tone_duty_reg;
        elapsed_next   = elapsed_reg;
        phase_next     = phase_reg;
        tone_on_next   = tone_on_reg;
        siren_next     = siren_reg;
        freq_next      = freq_reg;
        duty_next      = duty_reg;
        factor_next    = factor_reg;
        divisor_next   = divisor_reg;
        product_next   = product_reg;
        acc            = 1'b0;
        res_push       = 1'b0;
        req_take       = 1'b0;
        div_start      = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                if (req_valid && !res_full)
                begin
                    res_push = 1'b1;
                    req_take = 1'b1;
                    case (req.op)
                        OP_TICK:
                        begin
                            if (active_reg)
                            begin
                                elapsed_next = elapsed_inc;
                                if (elapsed_inc >= total_reg)
                                begin
                                    // end of play, frequency kept
                                    duty_next   = '0;
                                    active_next = 1'b0;
                                end
                                else if (pulsed)
                                begin
                                    phase_next = phase_dec;
                                    if (phase_dec == '0)
                                    begin
                                        case (pattern_reg)
                                            PAT_SIREN:
                                            begin
                                                siren_next = !siren_reg;
                                                freq_next  = clamp_val(
                                                    !siren_reg ? siren_hi : FACT_W'(base_reg),
                                                    cfg.freq_min, cfg.freq_max);
                                                duty_next  = tone_duty_reg;
                                                phase_next = SIREN_HALF_MS;
                                            end
                                            PAT_ALARM:
                                            begin
                                                tone_on_next = !tone_on_reg;
                                                duty_next    = !tone_on_reg ? tone_duty_reg : '0;
                                                phase_next   = !tone_on_reg ? ALARM_TONE_MS
                                                                            : ALARM_GAP_MS;
                                            end
                                            default:
                                            begin
                                                // rise or fall sweep step
                                                phase_next = SWEEP_PERIOD_MS;
                                                if (total_reg == '0)
                                                begin
                                                    freq_next = clamp_val(FACT_W'(base_reg),
                                                        cfg.freq_min, cfg.freq_max);
                                                    duty_next = tone_duty_reg;
                                                end
                                                else
                                                begin
                                                    res_push   = 1'b0;
                                                    req_take   = 1'b0;
                                                    state_next = BK_MUL;
                                                    if (pattern_reg == PAT_RISE)
                                                    begin
                                                        factor_next  = FACT_W'(total_reg) + elapsed_x3;
                                                        divisor_next = FACT_W'(total_reg);
                                                    end
                                                    else
                                                    begin
                                                        factor_next  = {total_reg, 2'b00} - elapsed_x3;
                                                        divisor_next = {total_reg, 2'b00};
                                                    end
                                                end
                                            end
                                        endcase
                                    end
                                end
                            end
                        end
                        OP_PLAY:
                        begin
                            acc            = 1'b1;
                            pattern_next   = req.pattern;
                            base_next      = req.freq;
                            total_next     = req.dur;
                            tone_duty_next = req.duty;
                            elapsed_next   = '0;
                            tone_on_next   = 1'b1;
                            siren_next     = 1'b0;
                            active_next    = 1'b1;
                            freq_next      = clamp_val(FACT_W'(req.freq), cfg.freq_min,
                                                       cfg.freq_max);
                            duty_next      = req.duty;
                            case (req.pattern)
                                PAT_SIREN: phase_next = SIREN_HALF_MS;
                                PAT_ALARM: phase_next = ALARM_TONE_MS;
                                PAT_RISE:  phase_next = SWEEP_PERIOD_MS;
                                PAT_FALL:  phase_next = SWEEP_PERIOD_MS;
                                default:   phase_next = '0;
                            endcase
                        end
                        OP_STOP:
                        begin
                            if (active_reg)
                            begin
                                duty_next   = '0;
                                active_next = 1'b0;
                            end
                        end
                        default:
                        begin
                            // rejected play or ignored kind: report state as is
                        end
                    endcase
                end
            end
            BK_MUL:
            begin
                product_next = PROD_W'(base_reg) * PROD_W'(factor_reg);
                state_next   = BK_LOAD;
            end
            BK_LOAD:
            begin
                div_start  = 1'b1;
                state_next = BK_DIV;
            end
            BK_DIV:
            begin
                if (div_done)
                begin
                    freq_next  = clamp_val(div_quo, cfg.freq_min, cfg.freq_max);
                    duty_next  = tone_duty_reg;
                    res_push   = 1'b1;
                    req_take   = 1'b1;
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    assign res_in.freq     = freq_next;
    assign res_in.duty     = duty_next;
    assign res_in.playing  = active_next;
    assign res_in.accepted = acc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            active_reg    <= 1'b0;
            pattern_reg   <= PAT_BEEP;
            base_reg      <= '0;
            total_reg     <= '0;
            tone_duty_reg <= '0;
            elapsed_reg   <= '0;
            phase_reg     <= '0;
            tone_on_reg   <= 1'b1;
            siren_reg     <= 1'b0;
            freq_reg      <= '0;
            duty_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            active_reg    <= active_next;
            pattern_reg   <= pattern_next;
            base_reg      <= base_next;
            total_reg     <= total_next;
            tone_duty_reg <= tone_duty_next;
            elapsed_reg   <= elapsed_next;
            phase_reg     <= phase_next;
            tone_on_reg   <= tone_on_next;
            siren_reg     <= siren_next;
            freq_reg      <= freq_next;
            duty_reg      <= duty_next;
        end
    end

    // sweep operands
    always_ff @(posedge clk)
    begin
        factor_reg  <= factor_next;
        divisor_reg <= divisor_next;
        product_reg <= product_next;
    end

    // result queue
    assign res_full = (res_cnt_reg == RES_CNT_W'(RES_DEPTH));
    assign empty    = (res_cnt_reg == '0);
    assign res_pop  = pop && !empty;
    assign res_head = res_mem[res_rd_reg];

    always_comb
    begin
        res_wr_next = res_wr_reg;
        res_rd_next = res_rd_reg;
        if (res_push)
        begin
            res_wr_next = (res_wr_reg == RES_PTR_W'(RES_DEPTH - 1)) ? '0 : res_wr_reg + 1'b1;
        end
        if (res_pop)
        begin
            res_rd_next = (res_rd_reg == RES_PTR_W'(RES_DEPTH - 1)) ? '0 : res_rd_reg + 1'b1;
        end
        res_cnt_next = res_cnt_reg + RES_CNT_W'(res_push) - RES_CNT_W'(res_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_wr_reg  <= '0;
            res_rd_reg  <= '0;
            res_cnt_reg <= '0;
        end
        else
        begin
            res_wr_reg  <= res_wr_next;
            res_rd_reg  <= res_rd_next;
            res_cnt_reg <= res_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_push)
        begin
            res_mem[res_wr_reg] <= res_in;
        end
    end

    `TPS_ASSERT_IMPL(a_push_has_room, clk, rst_n, res_push, res_cnt_reg < RES_CNT_W'(RES_DEPTH))
    `TPS_ASSERT_IMPL(a_div_done_in_div, clk, rst_n, div_done, state_reg == BK_DIV)
    `TPS_ASSERT_IMPL(a_sweep_only_active, clk, rst_n, state_reg != BK_IDLE,
        active_reg && (pattern_reg == PAT_RISE || pattern_reg == PAT_FALL))
    `TPS_ASSERT_IMPL(a_accept_plays, clk, rst_n, res_push && acc, active_next)
    `TPS_ASSERT_NEXT(a_load_starts_div, clk, rst_n, state_reg == BK_LOAD, state_reg == BK_DIV)

endmodule
